[rtl/uart_tx_8n1_fifo_unit_macros.svh]
// ----------------------------------------------------------------------------
// uart_tx_8n1_fifo_unit assertion macros
// Shared concurrent-assertion wrappers for the transmitter's checker.
// ----------------------------------------------------------------------------
`ifndef UART_TX_8N1_FIFO_UNIT_MACROS_SVH
`define UART_TX_8N1_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define UTX_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utx assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define UTX_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utx assertion failed");

`endif

[rtl/utx_pkg.sv]
// ----------------------------------------------------------------------------
// utx_pkg
// Types and constants shared by the 8N1 transmitter front end, back end
// and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utx_pkg;

   localparam int DATA_W   = 8;
   localparam int BITPOS_W = 4;
   localparam int QUEUED_W = 4;

   // bit position codes: 0 = start bit, 1..8 = data bits, 9 = stop bit
   localparam logic [BITPOS_W-1:0] START_POSITION = 4'd0;
   localparam logic [BITPOS_W-1:0] STOP_POSITION  = 4'd9;

   // transaction opcode
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic                tx_line;
      logic                running;
      logic [QUEUED_W-1:0] queued;
      logic                accepted;
      logic                overflow;
   } rsp_payload_type;

   // classified command handed from front end to back end
   typedef struct packed {
      logic              is_push;
      logic              is_tick;
      logic [DATA_W-1:0] data_byte;
   } cmd_type;

endpackage

[rtl/uart_tx_8n1_fifo_unit.sv]
// ----------------------------------------------------------------------------
// uart_tx_8n1_fifo_unit
// 8N1 serial transmitter on a byte ring, one transaction per unstalled cycle.
// ----------------------------------------------------------------------------
// Each request is either a push (queue data_byte) or a tick (one bit time on
// the line: start low, eight data bits LSB first, stop high). Every request
// yields exactly one response with the line level, running flag, queue
// occupancy (modulo 16), push acceptance and the sticky overflow flag. The
// block sustains one request per clock while responses are taken; a
// response is offered once its request has passed the two-entry command
// queue register and been captured in the response register. The ring
// holds QUEUE_DEPTH bytes of storage, at most QUEUE_DEPTH-1 of them queued;
// a push into a full ring is dropped and sets overflow until reset. The
// ring needs no clearing after reset.
`timescale 1ns / 1ps

module uart_tx_8n1_fifo_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  utx_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output utx_pkg::rsp_payload_type rsp_payload
);

   logic             cmd_valid;
   logic             cmd_ready;
   utx_pkg::cmd_type cmd;

   // front end: accept and classify
   utx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // back end: ring, frame sequencer, response register
   utx_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/utx_front.sv]
// ----------------------------------------------------------------------------
// utx_front
// Accepts request transactions, classifies them into push or tick commands
// and holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  utx_pkg::req_payload_type req_payload,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output utx_pkg::cmd_type         cmd
);

   localparam int SLOTS = 2;

   utx_pkg::cmd_type slot_ff [SLOTS];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   utx_pkg::cmd_type cmd_new;
   logic             push, pop;

   // classify the incoming transaction
   always_comb begin
      cmd_new.is_push   = (req_payload.op == utx_pkg::OP_PUSH);
      cmd_new.is_tick   = (req_payload.op == utx_pkg::OP_TICK);
      cmd_new.data_byte = req_payload.data_byte;
   end

   assign req_ready = (count_ff != 2'(SLOTS));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = slot_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[rtl/utx_back.sv]
// ----------------------------------------------------------------------------
// utx_back
// Executes push and tick commands: byte ring memory, frame sequencer,
// sticky overflow flag and the registered response stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  utx_pkg::cmd_type         cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output utx_pkg::rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int EXT_W = (IDX_W > utx_pkg::QUEUED_W) ? IDX_W : utx_pkg::QUEUED_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [IDX_W-1:0] DEPTH_MOD = IDX_W'(QUEUE_DEPTH);

   logic [utx_pkg::DATA_W-1:0]   mem [QUEUE_DEPTH];
   logic [utx_pkg::DATA_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]             wr_idx_ff, wr_idx_in;
   logic [utx_pkg::BITPOS_W-1:0] bit_pos_ff, bit_pos_in;
   logic [utx_pkg::DATA_W-1:0]   shift_ff, shift_in;
   logic                         line_ff, line_in;
   logic                         run_ff, run_in;
   logic                         ovf_ff, ovf_in;
   logic                         rsp_valid_ff;
   utx_pkg::rsp_payload_type     rsp_ff, rsp_in;
   logic                         fire, full, wr_en, acc;
   logic [IDX_W-1:0]             wr_next, rd_next, count;
   logic [EXT_W-1:0]             count_ext;

   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign fire        = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign wr_next = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
   assign full    = (wr_next == rd_idx_ff);

   // command execution
   always_comb begin
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      bit_pos_in = bit_pos_ff;
      shift_in   = shift_ff;
      line_in    = line_ff;
      run_in     = run_ff;
      ovf_in     = ovf_ff;
      wr_en      = 1'b0;
      acc        = 1'b0;
      if (fire && cmd.is_push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            wr_en     = 1'b1;
            acc       = 1'b1;
            wr_idx_in = wr_next;
            if (rd_idx_ff == wr_idx_ff) begin
               run_in = 1'b1;
            end
         end
      end else if (fire && cmd.is_tick && run_ff) begin
         if (bit_pos_ff == utx_pkg::START_POSITION) begin
            line_in    = 1'b0;
            bit_pos_in = bit_pos_ff + 1'b1;
            shift_in   = rd_data_ff;
         end else if (bit_pos_ff < utx_pkg::STOP_POSITION) begin
            line_in    = shift_ff[0];
            shift_in   = {1'b0, shift_ff[utx_pkg::DATA_W-1:1]};
            bit_pos_in = bit_pos_ff + 1'b1;
         end else begin
            line_in    = 1'b1;
            rd_idx_in  = rd_next;
            bit_pos_in = utx_pkg::START_POSITION;
            if (rd_next == wr_idx_ff) begin
               run_in = 1'b0;
            end
         end
      end
   end

   // occupancy after this transaction, reported modulo 16
   always_comb begin
      if (wr_idx_in >= rd_idx_in) begin
         count = wr_idx_in - rd_idx_in;
      end else begin
         count = wr_idx_in - rd_idx_in + DEPTH_MOD;
      end
      count_ext = EXT_W'(count);
   end

   always_comb begin
      rsp_in.tx_line  = line_in;
      rsp_in.running  = run_in;
      rsp_in.queued   = count_ext[utx_pkg::QUEUED_W-1:0];
      rsp_in.accepted = acc;
      rsp_in.overflow = ovf_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         bit_pos_ff   <= utx_pkg::START_POSITION;
         line_ff      <= 1'b1;
         run_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         bit_pos_ff <= bit_pos_in;
         line_ff    <= line_in;
         run_ff     <= run_in;
         ovf_ff     <= ovf_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // byte ring: one write port, registered read of the next head entry
   // with bypass so a byte pushed into an empty ring is seen at once
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx_ff] <= cmd.data_byte;
      end
      if (wr_en && (wr_idx_ff == rd_idx_in)) begin
         rd_data_ff <= cmd.data_byte;
      end else begin
         rd_data_ff <= mem[rd_idx_in];
      end
   end

endmodule

[rtl/utx_checker.sv]
// ----------------------------------------------------------------------------
// utx_checker
// Port-level checks on the transmitter's response channel, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_tx_8n1_fifo_unit_macros.svh"

module utx_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input utx_pkg::rsp_payload_type rsp_payload
);

   // stalled response holds
   `UTX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // overflow stays set in later responses
   `UTX_ASSERT_NEXT(a_ovf_sticky, clock, reset, rsp_valid && rsp_ready && rsp_payload.overflow, !rsp_valid || rsp_payload.overflow)
   // stopped clock means empty ring and idle line
   `UTX_ASSERT_SAME(a_idle_empty, clock, reset, rsp_valid && !rsp_payload.running, (rsp_payload.queued == 4'd0) && rsp_payload.tx_line)
   // no response right after reset
   `UTX_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind uart_tx_8n1_fifo_unit utx_checker u_utx_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[test/utx_tx_checker.sv]
// ----------------------------------------------------------------------------
// utx_tx_checker
// Watches both channels of the 8N1 transmitter, keeps its own model of the
// byte ring, bit counter and line, and compares every response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utx_tx_checker #(
   parameter int RING_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  utx_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  utx_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       pending_results
);

   // transmitter model state
   logic [utx_pkg::DATA_W-1:0]   byte_ring [RING_DEPTH];
   int                           rd_idx;
   int                           wr_idx;
   logic [utx_pkg::BITPOS_W-1:0] bit_pos;
   logic                         line_lvl;
   logic                         clk_on;
   logic                         ovf_sticky;

   // responses still owed by the block, oldest first
   utx_pkg::rsp_payload_type line_status_q [$];

   // apply one request to the model and return the response it should give
   function automatic utx_pkg::rsp_payload_type transmit_step(
      utx_pkg::req_payload_type item);
      utx_pkg::rsp_payload_type r;
      int nxt;
      int occ;
      r = '0;
      if (item.op == utx_pkg::OP_PUSH) begin
         nxt = (wr_idx + 1) % RING_DEPTH;
         if (nxt == rd_idx) begin
            // full ring: byte dropped
            ovf_sticky = 1'b1;
         end else begin
            byte_ring[wr_idx] = item.data_byte;
            if (rd_idx == wr_idx) clk_on = 1'b1;
            wr_idx = nxt;
            r.accepted = 1'b1;
         end
      end else if (clk_on) begin
         if (bit_pos == utx_pkg::START_POSITION) begin
            line_lvl = 1'b0;
            bit_pos = utx_pkg::START_POSITION + 1'b1;
         end else if (bit_pos < utx_pkg::STOP_POSITION) begin
            // data bits go out LSB first
            line_lvl = byte_ring[rd_idx][bit_pos - 1'b1];
            bit_pos = bit_pos + 1'b1;
         end else begin
            // stop bit retires the byte
            line_lvl = 1'b1;
            rd_idx = (rd_idx + 1) % RING_DEPTH;
            if (rd_idx == wr_idx) clk_on = 1'b0;
            bit_pos = utx_pkg::START_POSITION;
         end
      end
      occ = (wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH;
      r.tx_line  = line_lvl;
      r.running  = clk_on;
      r.queued   = occ[utx_pkg::QUEUED_W-1:0];
      r.overflow = ovf_sticky;
      return r;
   endfunction

   task automatic check_field(string label, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t checker: %s expected %0h, got %0h", $time, label, want, got);
      end
   endtask

   // predict on each request transaction, compare on each response transaction
   always @(posedge clock) begin
      utx_pkg::rsp_payload_type want;
      if (reset) begin
         rd_idx     = 0;
         wr_idx     = 0;
         bit_pos    = utx_pkg::START_POSITION;
         line_lvl   = 1'b1;
         clk_on     = 1'b0;
         ovf_sticky = 1'b0;
         line_status_q.delete();
      end else begin
         if (req_valid && req_ready)
            line_status_q.push_back(transmit_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (line_status_q.size() == 0) begin
               error_count++;
               $display("%0t checker: expected no response, got %h", $time, rsp_payload);
            end else begin
               want = line_status_q.pop_front();
               check_field("tx_line", want.tx_line, rsp_payload.tx_line);
               check_field("running", want.running, rsp_payload.running);
               check_field("queued", want.queued, rsp_payload.queued);
               check_field("accepted", want.accepted, rsp_payload.accepted);
               check_field("overflow", want.overflow, rsp_payload.overflow);
            end
         end
      end
      pending_results <= line_status_q.size();
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the 8N1 transmitter: a directed frame walk, random mixes of
// pushes and bit ticks under random flow control, then a ring fill to
// overflow and a full drain. Checking lives in utx_tx_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   utx_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   utx_pkg::rsp_payload_type rsp_payload;
   int                       check_errors;
   int                       owed;

   // sender idling: 0 = random gaps, otherwise back-to-back
   logic                     sender_burst;
   int                       sent;

   uart_tx_8n1_fifo_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   utx_tx_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .error_count     (check_errors),
      .pending_results (owed)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // one request transaction; called right after a falling edge
   task automatic offer_request(utx_pkg::op_type op, logic [utx_pkg::DATA_W-1:0] data);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{op: op, data_byte: data};
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      sent++;
   endtask

   task automatic send_ticks(int n);
      repeat (n) offer_request(utx_pkg::OP_TICK, 8'($urandom));
   endtask

   // response side: random stalls with calm stretches
   initial begin
      int stall;
      int calm_left;
      rsp_ready = 1'b0;
      calm_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            stall = 0;
            calm_left = $urandom_range(10, 60);
         end else begin
            stall = $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // main stimulus
   initial begin
      int seg_len;
      int push_odds;
      req_valid    = 1'b0;
      req_payload  = '0;
      reset        = 1'b1;
      sender_burst = 1'b0;
      sent         = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: tick while stopped, two frames of extreme bytes with a push
      // landing mid-frame, then a tick after the clock has stopped
      send_ticks(1);
      offer_request(utx_pkg::OP_PUSH, 8'hFF);
      send_ticks(3);
      offer_request(utx_pkg::OP_PUSH, 8'h00);
      send_ticks(7);
      send_ticks(10);
      send_ticks(1);

      // random mixes; heavy push segments only late, since overflow sticks
      while (sent < 2000) begin
         seg_len = $urandom_range(20, 120);
         sender_burst = ($urandom_range(0, 3) == 0);
         if (sent > 1500 && $urandom_range(0, 2) == 0)
            push_odds = 3;
         else
            case ($urandom_range(0, 2))
               0: push_odds = 6;
               1: push_odds = 10;
               default: push_odds = 14;
            endcase
         repeat (seg_len) begin
            if ($urandom_range(1, push_odds) == 1)
               offer_request(utx_pkg::OP_PUSH, 8'($urandom));
            else
               offer_request(utx_pkg::OP_TICK, 8'($urandom));
         end
      end

      // fill the ring until a push is dropped, then drain every frame
      sender_burst = 1'b0;
      repeat (16) offer_request(utx_pkg::OP_PUSH, 8'($urandom));
      offer_request(utx_pkg::OP_PUSH, 8'h80);
      send_ticks(160);

      req_valid <= 1'b0;
      wait (owed == 0);
      repeat (8) @(posedge clock);
      if (check_errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb: errors");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/utx_pkg.sv
rtl/utx_front.sv
rtl/utx_back.sv
rtl/uart_tx_8n1_fifo_unit.sv
rtl/utx_checker.sv
test/utx_tx_checker.sv
test/tb.sv
